### hw/rtl/srfc_pkg.sv
`timescale 1ns / 1ps

package srfc_pkg;

    localparam int unsigned PAYLOAD_DEPTH = 15;
    localparam int unsigned WORD_COUNT    = 7;
    localparam int unsigned HEADER_BYTES  = 3;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_READ = 8'h03;
    localparam logic [7:0]  LEN_SHORT = 8'd3;
    localparam logic [7:0]  LEN_LONG  = 8'd15;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
    localparam logic [8:0]  COUNT_MAX = 9'd511;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_FRAME = 2'd2;

    localparam logic [1:0] CFG_WIND     = 2'd0;
    localparam logic [1:0] CFG_CO       = 2'd1;
    localparam logic [1:0] CFG_RESIDUAL = 2'd2;
    localparam logic [1:0] CFG_SEVEN    = 2'd3;

    localparam logic [3:0] QTY_WIND       = 4'd0;
    localparam logic [3:0] QTY_CO         = 4'd1;
    localparam logic [3:0] QTY_RESIDUAL   = 4'd2;
    localparam logic [3:0] QTY_SEVEN_BASE = 4'd3;
    localparam logic [2:0] LAST_WORD      = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
        logic [7:0] expected_address;
        logic [3:0] sensor_slot;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  slot_out;
        logic [1:0]  status;
        logic [7:0]  model_code;
        logic [3:0]  quantity;
        logic [15:0] reading;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic [3:0]                   slot;
        logic [1:0]                   status;
        logic [7:0]                   model;
        logic [3:0]                   quantity;
        logic                         seven;
        logic [WORD_COUNT-1:0][15:0]  words;
    } frame_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

### hw/rtl/sensor_response_frame_checker.sv
`timescale 1ns / 1ps
// accepts one frame byte per cycle while in_ready is high; crc and counters update at the byte's edge
// final byte to first result: the frame is written into the queue, then its first result into the output register
// results leave at one per cycle while out_ready is high, 1 or 7 per frame; a 2-entry frame queue lets bytes
// of the next frame flow while results drain, input stalls only when both entries wait
// reset: crc 0xFFFF, byte count 0, queue and output empty, model codes 1, 2, 3, 4
module sensor_response_frame_checker
    import srfc_pkg::*;
#(
    parameter int SENSOR_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic   push, push_ready, head_valid, pop;
    frame_t push_frame, head_frame;

    srfc_front #(
        .SENSOR_SLOTS(SENSOR_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    srfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .head_valid (head_valid),
        .pop        (pop),
        .head_frame (head_frame)
    );

    srfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .pop        (pop),
        .head_frame (head_frame),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

### hw/rtl/srfc_front.sv
`timescale 1ns / 1ps

module srfc_front
    import srfc_pkg::*;
#(
    parameter int SENSOR_SLOTS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       push,
    input  logic       push_ready,
    output frame_t     push_frame
);

    logic [15:0] crc_reg, crc_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [7:0]  addr_reg, func_reg, len_reg;
    logic [7:0]  store_reg [PAYLOAD_DEPTH];
    logic [7:0]  code_reg [4];
    logic        accept;
    logic [15:0] crc_upd;
    logic [8:0]  cnt_inc;
    logic [8:0]  store_pos;
    logic [7:0]  model;
    logic [1:0]  status;
    logic [3:0]  quantity;
    logic        seven;

    assign in_ready  = push_ready;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign crc_upd   = crc_byte(crc_reg, in_data.rx_byte);
    assign cnt_inc   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 9'd1;
    assign store_pos = cnt_reg - 9'd3;
    assign model     = store_reg[0];

    // frame checks on the final byte
    always_comb
    begin
        status   = ST_OK;
        quantity = QTY_WIND;
        seven    = 1'b0;
        if (cnt_inc < FRAME_OVERHEAD)
            status = ST_FRAME;
        else if (crc_upd != 16'h0000)
            status = ST_CRC;
        else if (addr_reg != in_data.expected_address || func_reg != FUNC_READ)
            status = ST_FRAME;
        else if (cnt_inc != {1'b0, len_reg} + FRAME_OVERHEAD)
            status = ST_FRAME;
        else if (len_reg != LEN_SHORT && len_reg != LEN_LONG)
            status = ST_FRAME;
        else if ({5'b0, in_data.sensor_slot} >= 9'(SENSOR_SLOTS))
            status = ST_FRAME;
        else if (model == code_reg[CFG_WIND])
            quantity = QTY_WIND;
        else if (model == code_reg[CFG_CO])
            quantity = QTY_CO;
        else if (model == code_reg[CFG_RESIDUAL])
            quantity = QTY_RESIDUAL;
        else if (model == code_reg[CFG_SEVEN])
        begin
            quantity = QTY_SEVEN_BASE;
            seven    = 1'b1;
        end
        else
            status = ST_FRAME;

        if (status == ST_OK && (seven ? (len_reg != LEN_LONG) : (len_reg != LEN_SHORT)))
            status = ST_FRAME;
    end

    always_comb
    begin
        push_frame.slot     = in_data.sensor_slot;
        push_frame.status   = status;
        push_frame.model    = (status == ST_OK) ? model : 8'h00;
        push_frame.quantity = (status == ST_OK) ? quantity : QTY_WIND;
        push_frame.seven    = (status == ST_OK) && seven;
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            push_frame.words[i] = {store_reg[1 + 2 * i], store_reg[2 + 2 * i]};
        end
    end

    assign push = accept && in_data.end_of_frame;

    assign crc_next = (accept && in_data.end_of_frame) ? CRC_INIT : (accept ? crc_upd : crc_reg);
    assign cnt_next = (accept && in_data.end_of_frame) ? 9'd0 : (accept ? cnt_inc : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            cnt_reg     <= 9'd0;
            code_reg[0] <= 8'd1;
            code_reg[1] <= 8'd2;
            code_reg[2] <= 8'd3;
            code_reg[3] <= 8'd4;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready)
                code_reg[cfg_index] <= cfg_data;
        end
    end

    // header and payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cnt_reg == 9'd0)
                addr_reg <= in_data.rx_byte;
            else if (cnt_reg == 9'd1)
                func_reg <= in_data.rx_byte;
            else if (cnt_reg == 9'd2)
                len_reg <= in_data.rx_byte;
            else if (store_pos < 9'(PAYLOAD_DEPTH))
                store_reg[store_pos[3:0]] <= in_data.rx_byte;
        end
    end

endmodule

### hw/rtl/srfc_queue.sv
`timescale 1ns / 1ps

module srfc_queue
    import srfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   push_ready,
    input  frame_t push_frame,
    output logic   head_valid,
    input  logic   pop,
    output frame_t head_frame
);

    frame_t     slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign push_ready = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_frame = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_frame;
    end

endmodule

### hw/rtl/srfc_back.sv
`timescale 1ns / 1ps

module srfc_back
    import srfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    output logic      pop,
    input  frame_t    head_frame,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [2:0] word_reg;
    logic       valid_reg;
    out_item_t  out_reg;
    out_item_t  result;
    logic       load;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && result.last_result;

    always_comb
    begin
        result.slot_out = head_frame.slot;
        result.status   = head_frame.status;
        result.model_code = head_frame.model;
        if (head_frame.seven)
        begin
            result.quantity    = head_frame.quantity + {1'b0, word_reg};
            result.last_result = (word_reg == LAST_WORD);
        end
        else
        begin
            result.quantity    = head_frame.quantity;
            result.last_result = 1'b1;
        end
        result.reading = (head_frame.status == ST_OK) ? head_frame.words[word_reg] : 16'h0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            word_reg  <= result.last_result ? 3'd0 : word_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= result;
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule
